// ===== hw/rtl/htba_pkg.sv =====
// ---------------------------------------------------------------------------
// htba_pkg
// Shared types, sizes and helper functions for the handle table allocator.
// ---------------------------------------------------------------------------
package htba_pkg;

    localparam int SLOT_COUNT   = 1024;
    localparam int WORD_BITS    = 64;
    localparam int BIT_W        = 6;
    localparam int BITMAP_WORDS = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int WORD_W       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int TAIL_REM     = SLOT_COUNT % WORD_BITS;

    localparam int OP_W         = 2;
    localparam int HANDLE_W     = 16;
    localparam int DATA_W       = 32;
    localparam int RESULT_W     = 10;

    // Bits of the last bitmap word that lie beyond the table; they count as taken.
    localparam logic [WORD_BITS-1:0] TAIL_MASK =
        (TAIL_REM == 0) ? '0 : ~((64'd1 << TAIL_REM) - 64'd1);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOCATE = 2'd0,
        OP_INSTALL  = 2'd1,
        OP_LOOKUP   = 2'd2,
        OP_CLOSE    = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Lowest zero bit of a word in two steps: the first byte with a zero,
    // then the first zero bit inside that byte.
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [2:0] byte_sel;
        logic [2:0] bit_sel;
        logic [7:0] sel_byte;
        byte_sel = 3'd0;
        bit_sel  = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (w[i*8 +: 8] != 8'hFF)
            begin
                byte_sel = 3'(i);
            end
        end
        sel_byte = w[byte_sel*8 +: 8];
        for (int j = 7; j >= 0; j--) begin
            if (!sel_byte[j])
            begin
                bit_sel = 3'(j);
            end
        end
        return {byte_sel, bit_sel};
    endfunction

    // Lowest bitmap word that still has a free slot.
    function automatic logic [WORD_W-1:0] first_open(input logic [BITMAP_WORDS-1:0] full);
        logic [WORD_W-1:0] idx;
        idx = '0;
        for (int i = BITMAP_WORDS - 1; i >= 0; i--) begin
            if (!full[i])
            begin
                idx = WORD_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/htba_ram.sv =====
// ---------------------------------------------------------------------------
// htba_ram
// Generic single-port synchronous RAM with a registered read.
// ---------------------------------------------------------------------------
module htba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                             wdata,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rd_data_reg <= mem_reg[addr];
    end

    assign rdata = rd_data_reg;

endmodule

// ===== hw/rtl/handle_table_bitmap_allocator.sv =====
// ---------------------------------------------------------------------------
// handle_table_bitmap_allocator
// Handle table with a bitmap slot allocator: allocate, install, lookup, close.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one request per transfer:
// op, slot_index, object_ref and access_rights. Every request gives exactly
// one response on the output channel (out_valid, out_stall): ok,
// result_index, found_ref and found_rights.
// A request is read in the idle state and finished in the execute state:
// the first reads the bitmap word and the slot entry from their single-port
// RAMs, the second modifies and writes them back and loads the response
// register. Each store has a single RAM port, so the block works on one
// request at a time, and the response comes from the response register.
// A per-word full flag picks the allocation word without a scan.
// The response register lets the next request be taken while a response
// waits; when the receiver stalls, the following request holds in the
// write cycle until the response register frees.
// Reset clears the full flags and a valid flag per bitmap word; a slot
// whose bitmap bit is clear reads as zero, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module handle_table_bitmap_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [htba_pkg::OP_W-1:0]     op,
    input  logic [htba_pkg::HANDLE_W-1:0] slot_index,
    input  logic [htba_pkg::DATA_W-1:0]   object_ref,
    input  logic [htba_pkg::DATA_W-1:0]   access_rights,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [htba_pkg::RESULT_W-1:0] result_index,
    output logic [htba_pkg::DATA_W-1:0]   found_ref,
    output logic [htba_pkg::DATA_W-1:0]   found_rights
);

    import htba_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic in_accept;
    logic done;

    // Captured request.
    op_t                  op_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [DATA_W-1:0]    ref_reg;
    logic [DATA_W-1:0]    rights_reg;
    logic                 in_range_reg;
    logic                 avail_reg;

    logic [BITMAP_WORDS-1:0] word_valid_reg;
    logic [BITMAP_WORDS-1:0] word_full_reg;

    logic                 out_valid_reg;
    logic                 ok_reg;
    logic [RESULT_W-1:0]  result_index_reg;
    logic [DATA_W-1:0]    found_ref_reg;
    logic [DATA_W-1:0]    found_rights_reg;

    // RAM ports.
    logic                  occ_we;
    logic [WORD_W-1:0]     occ_addr;
    logic [WORD_BITS-1:0]  occ_wdata;
    logic [WORD_BITS-1:0]  occ_rdata;
    logic                  slot_we;
    logic [SLOT_W-1:0]     slot_addr;
    logic [2*DATA_W-1:0]   slot_wdata;
    logic [2*DATA_W-1:0]   slot_rdata;

    // Request decode and execute-cycle values.
    logic                  req_in_range;
    logic [WORD_W-1:0]     req_word;
    logic [WORD_BITS-1:0]  occ_word;
    logic [WORD_BITS-1:0]  tail_mask;
    logic [BIT_W-1:0]      alloc_bit;
    logic [31:0]           cand_wide;
    logic [SLOT_W-1:0]     cand;
    logic [BIT_W-1:0]      slot_bit;
    logic                  slot_hit;
    logic [DATA_W-1:0]     cur_ref;
    logic [DATA_W-1:0]     cur_rights;
    logic [WORD_BITS-1:0]  new_word;

    logic                  ok_next;
    logic [RESULT_W-1:0]   result_index_next;
    logic [DATA_W-1:0]     found_ref_next;
    logic [DATA_W-1:0]     found_rights_next;

    assign in_accept    = in_valid && !in_stall;
    assign req_in_range = {1'b0, slot_index} < (HANDLE_W + 1)'(SLOT_COUNT);
    assign req_word     = (op == OP_ALLOCATE) ? first_open(word_full_reg)
                                              : WORD_W'(slot_index >> BIT_W);

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        done     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_EXEC:
            begin
                done = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // ---------------- execute datapath ----------------
    assign occ_word  = word_valid_reg[word_reg] ? occ_rdata : '0;
    assign tail_mask = (word_reg == WORD_W'(BITMAP_WORDS - 1)) ? TAIL_MASK : '0;
    assign alloc_bit = lowest_zero(occ_word | tail_mask);
    assign cand_wide = (32'(word_reg) << BIT_W) | 32'(alloc_bit);
    assign cand      = cand_wide[SLOT_W-1:0];
    assign slot_bit  = BIT_W'(slot_reg);
    assign slot_hit  = occ_word[slot_bit];

    // A slot whose bitmap bit is clear always reads as zeros.
    assign cur_ref    = slot_hit ? slot_rdata[2*DATA_W-1:DATA_W] : '0;
    assign cur_rights = slot_hit ? slot_rdata[DATA_W-1:0] : '0;

    always_comb
    begin
        occ_we            = 1'b0;
        slot_we           = 1'b0;
        new_word          = occ_word;
        slot_wdata        = {ref_reg, rights_reg};
        ok_next           = 1'b0;
        result_index_next = '0;
        found_ref_next    = '0;
        found_rights_next = '0;
        case (op_reg)
            OP_ALLOCATE:
            begin
                if (avail_reg)
                begin
                    new_word          = occ_word | (64'd1 << alloc_bit);
                    occ_we            = done;
                    slot_we           = done;
                    ok_next           = 1'b1;
                    result_index_next = RESULT_W'(cand);
                end
            end
            OP_INSTALL:
            begin
                if (in_range_reg)
                begin
                    new_word = occ_word | (64'd1 << slot_bit);
                    occ_we   = done;
                    slot_we  = done;
                    ok_next  = 1'b1;
                end
            end
            OP_LOOKUP:
            begin
                if (in_range_reg)
                begin
                    ok_next           = 1'b1;
                    found_ref_next    = cur_ref;
                    found_rights_next = cur_rights;
                end
            end
            default:
            begin
                if (in_range_reg && cur_ref != '0)
                begin
                    new_word   = occ_word & ~(64'd1 << slot_bit);
                    slot_wdata = '0;
                    occ_we     = done;
                    slot_we    = done;
                    ok_next    = 1'b1;
                end
            end
        endcase
    end

    // In the idle state the RAMs read for the incoming request; in the
    // execute state they address the captured request for the write back.
    assign occ_addr  = (state_reg == ST_IDLE) ? req_word : word_reg;
    assign occ_wdata = new_word;
    assign slot_addr = (state_reg == ST_IDLE) ? SLOT_W'(slot_index)
                     : ((op_reg == OP_ALLOCATE) ? cand : slot_reg);

    htba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BITMAP_WORDS)
    ) u_occ_ram (
        .clk   (clk),
        .we    (occ_we),
        .addr  (occ_addr),
        .wdata (occ_wdata),
        .rdata (occ_rdata)
    );

    htba_ram #(
        .WIDTH (2 * DATA_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .addr  (slot_addr),
        .wdata (slot_wdata),
        .rdata (slot_rdata)
    );

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            word_valid_reg <= '0;
            word_full_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (occ_we)
            begin
                word_valid_reg[word_reg] <= 1'b1;
                word_full_reg[word_reg]  <= &(new_word | tail_mask);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg       <= op_t'(op);
            slot_reg     <= SLOT_W'(slot_index);
            word_reg     <= req_word;
            ref_reg      <= object_ref;
            rights_reg   <= access_rights;
            in_range_reg <= req_in_range;
            avail_reg    <= !(&word_full_reg);
        end
        if (done)
        begin
            ok_reg           <= ok_next;
            result_index_reg <= result_index_next;
            found_ref_reg    <= found_ref_next;
            found_rights_reg <= found_rights_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign result_index = result_index_reg;
    assign found_ref    = found_ref_reg;
    assign found_rights = found_rights_reg;

endmodule

// ===== hw/rtl/htba_checker.sv =====
// ---------------------------------------------------------------------------
// htba_checker
// Port-level assertions for the handle table allocator, bound to the top.
// ---------------------------------------------------------------------------
module htba_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [htba_pkg::OP_W-1:0]     op,
    input logic [htba_pkg::HANDLE_W-1:0] slot_index,
    input logic [htba_pkg::DATA_W-1:0]   object_ref,
    input logic [htba_pkg::DATA_W-1:0]   access_rights,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          ok,
    input logic [htba_pkg::RESULT_W-1:0] result_index,
    input logic [htba_pkg::DATA_W-1:0]   found_ref,
    input logic [htba_pkg::DATA_W-1:0]   found_rights
);

    // A stalled response stays presented and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ok) && $stable(result_index)
            && $stable(found_ref) && $stable(found_rights))
        else $error("stalled response changed");

    // The block works on one request at a time: after a transfer it is busy.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while the previous one is in progress");

    // A failed request reports no slot and no data.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> result_index == '0 && found_ref == '0 && found_rights == '0)
        else $error("failed response carries data");

    // Only a successful allocate reports a nonzero slot, and it returns no data.
    a_index_alloc_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_index != '0 |-> ok && found_ref == '0 && found_rights == '0)
        else $error("slot index reported with lookup data or failure");

endmodule

bind handle_table_bitmap_allocator htba_checker u_htba_checker (.*);

// ===== bench/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the handle table allocator. Requests go in through
// the valid/stall channel with random bursts and gaps while the response side
// stalls on its own pattern. A scoreboard tracks the table contents and the
// occupancy of every slot, predicts each response and compares it field by
// field as it leaves the block.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import htba_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    localparam logic [1:0] STALL_NONE   = 2'd0;
    localparam logic [1:0] STALL_HOLD   = 2'd1;
    localparam logic [1:0] STALL_RANDOM = 2'd2;

    typedef struct packed {
        logic                ok;
        logic [RESULT_W-1:0] slot;
        logic [DATA_W-1:0]   obj;
        logic [DATA_W-1:0]   rights;
    } response_t;

    class handle_table_checker;
        bit              slot_taken  [SLOT_COUNT];
        bit [DATA_W-1:0] slot_objs   [SLOT_COUNT];
        bit [DATA_W-1:0] slot_rights [SLOT_COUNT];
        response_t       pending_responses[$];
        int              mismatches;

        // Lowest slot that is not taken, or -1 when the table is full.
        function int first_free_slot();
            int found;
            found = -1;
            for (int s = SLOT_COUNT - 1; s >= 0; s--)
            begin
                if (!slot_taken[s])
                begin
                    found = s;
                end
            end
            return found;
        endfunction

        function void fill_slot(input int s, input logic [DATA_W-1:0] obj,
                                input logic [DATA_W-1:0] rights);
            slot_taken[s]  = 1'b1;
            slot_objs[s]   = obj;
            slot_rights[s] = rights;
        endfunction

        function void note_request(input op_t code, input logic [HANDLE_W-1:0] handle,
                                   input logic [DATA_W-1:0] obj,
                                   input logic [DATA_W-1:0] rights);
            response_t expected;
            int        s;
            bit        in_range;
            expected = '0;
            in_range = int'(handle) < SLOT_COUNT;
            case (code)
                OP_ALLOCATE:
                begin
                    s = first_free_slot();
                    if (s >= 0)
                    begin
                        fill_slot(s, obj, rights);
                        expected.ok   = 1'b1;
                        expected.slot = RESULT_W'(s);
                    end
                end
                OP_INSTALL:
                begin
                    if (in_range)
                    begin
                        fill_slot(int'(handle), obj, rights);
                        expected.ok = 1'b1;
                    end
                end
                OP_LOOKUP:
                begin
                    if (in_range)
                    begin
                        expected.ok     = 1'b1;
                        expected.obj    = slot_objs[int'(handle)];
                        expected.rights = slot_rights[int'(handle)];
                    end
                end
                default:
                begin
                    // A slot holding a zero reference cannot be closed and stays taken.
                    if (in_range && slot_objs[int'(handle)] != '0)
                    begin
                        slot_taken[int'(handle)]  = 1'b0;
                        slot_objs[int'(handle)]   = '0;
                        slot_rights[int'(handle)] = '0;
                        expected.ok = 1'b1;
                    end
                end
            endcase
            pending_responses.push_back(expected);
        endfunction

        function void check_response(input logic ok_bit, input logic [RESULT_W-1:0] slot,
                                     input logic [DATA_W-1:0] obj,
                                     input logic [DATA_W-1:0] rights);
            response_t expected;
            if (pending_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("[%0t] unexpected response: ok=%0b index=%0d ref=%h rights=%h",
                             $time, ok_bit, slot, obj, rights);
                end
            end
            else
            begin
                expected = pending_responses.pop_front();
                if (ok_bit !== expected.ok || slot !== expected.slot ||
                    obj !== expected.obj || rights !== expected.rights)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("[%0t] response mismatch: expected ok=%0b index=%0d ref=%h rights=%h",
                                 $time, expected.ok, expected.slot, expected.obj, expected.rights);
                        $display("[%0t]                    actual   ok=%0b index=%0d ref=%h rights=%h",
                                 $time, ok_bit, slot, obj, rights);
                    end
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     op            = '0;
    logic [HANDLE_W-1:0] slot_index    = '0;
    logic [DATA_W-1:0]   object_ref    = '0;
    logic [DATA_W-1:0]   access_rights = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic                ok;
    logic [RESULT_W-1:0] result_index;
    logic [DATA_W-1:0]   found_ref;
    logic [DATA_W-1:0]   found_rights;

    handle_table_checker tracker;
    int                  burst_left  = 0;
    int                  cycle_count = 0;
    logic [1:0]          stall_mode  = STALL_NONE;
    int                  stall_run   = 0;

    handle_table_bitmap_allocator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .slot_index    (slot_index),
        .object_ref    (object_ref),
        .access_rights (access_rights),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ok            (ok),
        .result_index  (result_index),
        .found_ref     (found_ref),
        .found_rights  (found_rights)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // The receiver alternates between free-running, long holds and random stalls.
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode <= 2'($urandom_range(0, 2));
            stall_run  <= $urandom_range(4, 40);
        end
        else
        begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            STALL_HOLD:   out_stall <= 1'b1;
            STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
            default:      out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            tracker.check_response(ok, result_index, found_ref, found_rights);
        end
    end

    task automatic send_request(input op_t code, input logic [HANDLE_W-1:0] handle,
                                input logic [DATA_W-1:0] obj,
                                input logic [DATA_W-1:0] rights);
        int gap;
        in_valid      <= 1'b1;
        op            <= code;
        slot_index    <= handle;
        object_ref    <= obj;
        access_rights <= rights;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_request(code, handle, obj, rights);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            // A quarter of the bursts run straight into the next one.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_random(input int alloc_pct, input int install_pct, input int close_pct);
        op_t                 code;
        logic [HANDLE_W-1:0] handle;
        logic [DATA_W-1:0]   obj;
        logic [DATA_W-1:0]   rights;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct)
            code = OP_ALLOCATE;
        else if (pick < alloc_pct + install_pct)
            code = OP_INSTALL;
        else if (pick < alloc_pct + install_pct + close_pct)
            code = OP_CLOSE;
        else
            code = OP_LOOKUP;

        // Most handles land near the bottom of the table where allocation happens.
        pick = $urandom_range(0, 99);
        if (pick < 10)
            handle = HANDLE_W'($urandom_range(SLOT_COUNT, 65535));
        else if (pick < 60)
            handle = HANDLE_W'($urandom_range(0, 95));
        else
            handle = HANDLE_W'($urandom_range(0, SLOT_COUNT - 1));

        pick = $urandom_range(0, 99);
        obj = (pick < 12) ? '0 : (pick < 17) ? '1 : DATA_W'($urandom);
        pick = $urandom_range(0, 99);
        rights = (pick < 8) ? '0 : (pick < 12) ? '1 : DATA_W'($urandom);
        send_request(code, handle, obj, rights);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending_responses.size() != 0);
    endtask

    initial
    begin
        tracker = new;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_LOOKUP,   16'd0, '0, '0);
        send_request(OP_CLOSE,    16'd0, '0, '0);
        send_request(OP_ALLOCATE, 16'hFFFF, '1, '1);
        send_request(OP_ALLOCATE, 16'd0, '0, '0);
        send_request(OP_ALLOCATE, 16'h5555, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_request(OP_LOOKUP,   16'd0, '0, '0);
        send_request(OP_LOOKUP,   16'd1, '0, '0);
        send_request(OP_CLOSE,    16'd1, '0, '0);
        send_request(OP_ALLOCATE, 16'hAAAA, 32'h0000_0001, 32'h8000_0000);
        send_request(OP_INSTALL,  16'(SLOT_COUNT - 1), 32'h1234_5678, 32'h9ABC_DEF0);
        send_request(OP_LOOKUP,   16'(SLOT_COUNT - 1), '0, '0);
        send_request(OP_INSTALL,  16'(SLOT_COUNT), 32'hDEAD_BEEF, '1);
        send_request(OP_INSTALL,  16'hFFFF, '1, '1);
        send_request(OP_LOOKUP,   16'hFFFF, '0, '0);
        send_request(OP_LOOKUP,   16'(SLOT_COUNT), '0, '0);
        send_request(OP_CLOSE,    16'hFFFF, '0, '0);
        send_request(OP_INSTALL,  16'd0, 32'h8000_0000, 32'h0000_0001);
        send_request(OP_LOOKUP,   16'd0, '0, '0);
        send_request(OP_CLOSE,    16'd0, '0, '0);
        send_request(OP_LOOKUP,   16'd0, '0, '0);
        send_request(OP_ALLOCATE, 16'd0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        send_request(OP_CLOSE,    16'd2, '0, '0);
        send_request(OP_ALLOCATE, 16'd0, 32'h7FFF_FFFF, 32'h0000_FFFF);
        send_request(OP_INSTALL,  16'd64, 32'h0000_0040, 32'h0000_0040);
        hold_until_drained();

        repeat (250) send_random(30, 15, 25);
        hold_until_drained();

        repeat (3) send_request(OP_ALLOCATE, HANDLE_W'($urandom), DATA_W'($urandom), '1);
        repeat (150) send_random(40, 20, 20);
        repeat (170) send_random(25, 15, 30);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
